/* hdl/sha256_byte_stream_hasher_core_macros.svh */
// Assertion macros for the SHA-256 byte stream hasher core.
// Included by the top level; no other dependencies.
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define SHB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
// Next-cycle implication, disabled while reset is high.
`define SHB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define SHB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SHB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/shb_pkg.sv */
// Shared constants for the SHA-256 byte stream hasher: field widths,
// block geometry, initial hash values and round constants. No dependencies.
`default_nettype none

package shb_pkg;

   localparam int BYTE_W          = 8;
   localparam int WORD_W          = 32;
   localparam int DIGEST_LEN_W    = 6;
   localparam int BLOCK_BYTES     = 64;
   localparam int POS_W           = $clog2(BLOCK_BYTES);
   localparam int BLOCK_WORDS     = BLOCK_BYTES / 4;
   localparam int LENGTH_AT       = BLOCK_BYTES - 8;
   localparam int HASH_WORDS      = 8;
   localparam int ROUNDS          = 64;
   localparam int MAX_DIGEST      = 32;
   localparam int COUNT_W         = 61;
   localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;
   localparam logic [DIGEST_LEN_W-1:0] DIGEST_LEN_RESET = 6'd32;

   localparam logic [WORD_W-1:0] INIT_HASH [HASH_WORDS] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

/* hdl/shb_channel_if.sv */
// Valid/ready channel interfaces for the message byte input and the
// digest byte output. Depends on shb_pkg for field widths.
`default_nettype none

interface shb_req_if;
   logic                        valid;
   logic                        ready;
   logic [shb_pkg::BYTE_W-1:0]  message_byte;
   logic                        last_byte;

   modport source (output valid, output message_byte, output last_byte, input ready);
   modport sink   (input valid, input message_byte, input last_byte, output ready);
endinterface

interface shb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [shb_pkg::BYTE_W-1:0]  digest_byte;
   logic                        last_of_digest;
   logic                        length_error;

   modport source (output valid, output digest_byte, output last_of_digest,
                   output length_error, input ready);
   modport sink   (input valid, input digest_byte, input last_of_digest,
                   input length_error, output ready);
endinterface

`default_nettype wire

/* hdl/sha256_byte_stream_hasher_core.sv */
// SHA-256 byte stream hasher: one message byte per beat, one digest byte per beat.
// Each full block stalls input for 64 rounds on the shared round unit and a
// read-add-write of all 8 hash entries. After the last byte, padding goes in one
// byte per cycle except while a padded block compresses; each digest byte then
// takes a hash-memory read state and an output state that waits on back-pressure.
// Reset is synchronous; hash entries read as the initial hash until rewritten.
`default_nettype none
`include "sha256_byte_stream_hasher_core_macros.svh"

module sha256_byte_stream_hasher_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   shb_req_if.sink                                    req_bus,
   shb_rsp_if.source                                  rsp_bus,
   input  wire logic                                  csr_wr_en,
   input  wire logic [shb_pkg::DIGEST_LEN_W-1:0]      csr_wr_data
);

   typedef enum logic [2:0] {
      S_ABSORB, S_PAD, S_ROUND, S_FINAL, S_DG_RD, S_DG_WR
   } state_type;

   typedef enum logic [1:0] {
      PH_MSG, PH_MARK, PH_ZERO, PH_LEN
   } phase_type;

   localparam int WW = shb_pkg::WORD_W;
   localparam int BW = shb_pkg::BYTE_W;
   localparam int PW = shb_pkg::POS_W;
   localparam int CW = shb_pkg::COUNT_W;
   localparam int HW = shb_pkg::HASH_WORDS;
   localparam int LW = shb_pkg::DIGEST_LEN_W;
   localparam int BA = $clog2(shb_pkg::BLOCK_WORDS);
   localparam int HA = $clog2(shb_pkg::HASH_WORDS);

   // Memories: message block words and the running hash.
   logic [WW-1:0] blk_mem [shb_pkg::BLOCK_WORDS];
   logic [WW-1:0] hash_mem [HW];
   logic [WW-1:0] blk_rdata_ff;
   logic [WW-1:0] hm_rdata_ff;
   logic          hm_rvalid_ff;
   logic [HA-1:0] hm_raddr_ff;

   // Registers.
   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [5:0]    step_ff, step_in;
   logic [LW-1:0] dlen_ff, dlen_in;
   logic [23:0]   word_ff, word_in;
   logic [HW-1:0] hv_ff, hv_in;
   logic [WW-1:0] v_ff [HW];
   logic [WW-1:0] v_in [HW];
   logic [WW-1:0] w_ff [16];
   logic [WW-1:0] w_in [16];
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_err_ff, rsp_err_in;

   // Combinational signals.
   logic          req_acc;
   logic          push_en;
   logic [BW-1:0] push_byte;
   logic [WW-1:0] push_word;
   logic          pos_full;
   logic [PW-1:0] pos_next;
   logic [CW:0]   cnt_sum;
   logic [63:0]   len_bits;
   logic [BW-1:0] len_byte;
   logic          blk_we;
   logic [BA-1:0] blk_waddr;
   logic [BA-1:0] blk_raddr;
   logic          hm_we;
   logic [HA-1:0] hm_waddr;
   logic [HA-1:0] hm_raddr;
   logic [WW-1:0] hval;
   logic [WW-1:0] fin_sum;
   logic [WW-1:0] w_sched;
   logic [WW-1:0] w_cur;
   logic [WW-1:0] t1;
   logic [WW-1:0] t2;
   logic [LW-1:0] dlen_sat;
   logic          rsp_free;
   logic          dg_load;
   logic          dg_last;
   logic          restart;

   function automatic logic [WW-1:0] bsig0(input logic [WW-1:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WW-1:0] bsig1(input logic [WW-1:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [WW-1:0] ssig0(input logic [WW-1:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [WW-1:0] ssig1(input logic [WW-1:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   assign req_bus.ready          = (state_ff == S_ABSORB);
   assign req_acc                = req_bus.valid && (state_ff == S_ABSORB);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.digest_byte    = rsp_byte_ff;
   assign rsp_bus.last_of_digest = rsp_last_ff;
   assign rsp_bus.length_error   = rsp_err_ff;

   assign pos_full  = (pos_ff == PW'(shb_pkg::BLOCK_BYTES - 1));
   assign pos_next  = pos_ff + PW'(1);
   assign push_word = {word_ff, push_byte};
   assign cnt_sum   = {1'b0, cnt_ff} + (CW+1)'(1);
   assign len_bits  = {cnt_ff, 3'b000};
   assign len_byte  = len_bits[{~pos_ff[2:0], 3'b000} +: BW];
   assign dlen_sat  = (dlen_ff > LW'(shb_pkg::MAX_DIGEST)) ? LW'(shb_pkg::MAX_DIGEST) : dlen_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   // A hash entry that has not been written since the message began reads as
   // the initial value.
   assign hval    = hm_rvalid_ff ? hm_rdata_ff : shb_pkg::INIT_HASH[hm_raddr_ff];
   assign fin_sum = hval + v_ff[0];

   // The first 16 rounds take block words straight from memory; later rounds
   // extend the schedule from the sliding window.
   assign w_sched = ssig1(w_ff[14]) + w_ff[9] + ssig0(w_ff[1]) + w_ff[0];
   assign w_cur   = (step_ff[5:4] == 2'b00) ? blk_rdata_ff : w_sched;
   assign t1      = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
                    + shb_pkg::ROUND_K[step_ff] + w_cur;
   assign t2      = bsig0(v_ff[0])
                    + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   assign blk_we    = push_en && (pos_ff[1:0] == 2'b11);
   assign blk_waddr = pos_ff[PW-1:2];

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      dlen_in      = csr_wr_en ? csr_wr_data : dlen_ff;
      word_in      = word_ff;
      hv_in        = hv_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      push_en      = 1'b0;
      push_byte    = req_bus.message_byte;
      blk_raddr    = '0;
      hm_we        = 1'b0;
      hm_waddr     = step_ff[HA-1:0];
      hm_raddr     = '0;
      dg_load      = 1'b0;
      dg_last      = 1'b0;
      restart      = 1'b0;

      case (state_ff)
         S_ABSORB: begin
            if (req_acc) begin
               push_en = 1'b1;
               cnt_in  = cnt_sum[CW-1:0];
               if (cnt_sum[CW]) begin
                  ovf_in = 1'b1;
               end
               if (req_bus.last_byte) begin
                  phase_in = PH_MARK;
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            push_en = 1'b1;
            case (phase_ff)
               PH_MARK: push_byte = shb_pkg::PAD_MARK;
               PH_LEN:  push_byte = len_byte;
               default: push_byte = '0;
            endcase
            if (phase_ff != PH_LEN) begin
               phase_in = (pos_next == PW'(shb_pkg::LENGTH_AT)) ? PH_LEN : PH_ZERO;
            end
         end
         S_ROUND: begin
            blk_raddr = step_ff[BA-1:0] + BA'(1);
            v_in[0] = t1 + t2;
            v_in[1] = v_ff[0];
            v_in[2] = v_ff[1];
            v_in[3] = v_ff[2];
            v_in[4] = v_ff[3] + t1;
            v_in[5] = v_ff[4];
            v_in[6] = v_ff[5];
            v_in[7] = v_ff[6];
            for (int i = 0; i < 15; i++) begin
               w_in[i] = w_ff[i+1];
            end
            w_in[15] = w_cur;
            step_in  = step_ff + 6'd1;
            if (step_ff == 6'(shb_pkg::ROUNDS - 1)) begin
               step_in  = '0;
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            // Read-add-write of one hash entry per cycle; the sums rotate into
            // the working registers, which then hold the new hash.
            hm_raddr        = step_ff[HA-1:0] + HA'(1);
            hm_we           = 1'b1;
            hv_in[step_ff[HA-1:0]] = 1'b1;
            for (int i = 0; i < HW - 1; i++) begin
               v_in[i] = v_ff[i+1];
            end
            v_in[HW-1] = fin_sum;
            step_in    = step_ff + 6'd1;
            if (step_ff == 6'(HW - 1)) begin
               step_in = '0;
               case (phase_ff)
                  PH_MSG: state_in = S_ABSORB;
                  PH_LEN: begin
                     if (dlen_sat == '0) begin
                        restart = 1'b1;
                     end else begin
                        state_in = S_DG_RD;
                     end
                  end
                  default: state_in = S_PAD;
               endcase
            end
         end
         S_DG_RD: begin
            hm_raddr = step_ff[HA+1:2];
            state_in = S_DG_WR;
         end
         S_DG_WR: begin
            hm_raddr = step_ff[HA+1:2];
            if (rsp_free) begin
               dg_load      = 1'b1;
               dg_last      = ((step_ff + 6'd1) == dlen_sat);
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hval[{~step_ff[1:0], 3'b000} +: BW];
               rsp_last_in  = dg_last;
               rsp_err_in   = ovf_ff;
               if (dg_last) begin
                  restart = 1'b1;
               end else begin
                  step_in  = step_ff + 6'd1;
                  state_in = S_DG_RD;
               end
            end
         end
         default: state_in = S_ABSORB;
      endcase

      if (push_en) begin
         word_in = push_word[23:0];
         pos_in  = pos_next;
         if (pos_full) begin
            step_in  = '0;
            state_in = S_ROUND;
         end
      end

      if (restart) begin
         state_in = S_ABSORB;
         phase_in = PH_MSG;
         pos_in   = '0;
         cnt_in   = '0;
         ovf_in   = 1'b0;
         step_in  = '0;
         hv_in    = '0;
         v_in     = shb_pkg::INIT_HASH;
      end
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_waddr] <= push_word;
      end
      blk_rdata_ff <= blk_mem[blk_raddr];
   end

   always_ff @(posedge clock) begin
      if (hm_we) begin
         hash_mem[hm_waddr] <= fin_sum;
      end
      hm_rdata_ff <= hash_mem[hm_raddr];
   end

   always_ff @(posedge clock) begin
      hm_raddr_ff  <= hm_raddr;
      word_ff      <= word_in;
      w_ff         <= w_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
      if (reset) begin
         state_ff     <= S_ABSORB;
         phase_ff     <= PH_MSG;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         dlen_ff      <= shb_pkg::DIGEST_LEN_RESET;
         hv_ff        <= '0;
         hm_rvalid_ff <= 1'b0;
         v_ff         <= shb_pkg::INIT_HASH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         dlen_ff      <= dlen_in;
         hv_ff        <= hv_in;
         hm_rvalid_ff <= hv_ff[hm_raddr];
         v_ff         <= v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SHB_ASSERT_NEXT(a_round_to_final, clock, reset, (state_ff == S_ROUND) && (step_ff == 6'(shb_pkg::ROUNDS - 1)), state_ff == S_FINAL)
   `SHB_ASSERT_IMPL(a_digest_hash_written, clock, reset, (state_ff == S_DG_RD) || (state_ff == S_DG_WR), &hv_ff)
   `SHB_ASSERT_NEXT(a_restart_after_digest, clock, reset, dg_load && dg_last, (state_ff == S_ABSORB) && (pos_ff == '0) && (cnt_ff == '0) && !ovf_ff && (hv_ff == '0))

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking bench for sha256_byte_stream_hasher_core: message bytes go in, digest
// bytes come out, and each digest beat is checked against a SHA-256 predictor kept here.
// Depends on shb_pkg, the channel interfaces in shb_channel_if.sv, and the core itself.
`default_nettype none

module testbench;

   typedef enum logic [0:0] {STEP_BYTE, STEP_CSR} step_kind_e;

   typedef struct packed {
      step_kind_e  kind;
      logic [7:0]  value;
      logic        last;
      logic        has_typed;
      logic [7:0]  typed_byte;
   } stim_row_t;

   typedef struct packed {
      logic [shb_pkg::BYTE_W-1:0] digest_byte;
      logic                       last_of_digest;
      logic                       length_error;
   } digest_beat_t;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 400;
   localparam int RANDOM_PER_PHASE = 110;
   localparam int N_ROWS = 20;

   localparam logic [31:0] SHA_H0 [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // The first digest byte is typed in where it is well known: "abc" and a lone zero byte.
   localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
      '{STEP_BYTE, 8'h61, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'h62, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'h63, 1'b1, 1'b1, 8'hBA},
      '{STEP_BYTE, 8'h00, 1'b1, 1'b1, 8'h6E},
      '{STEP_CSR,  8'd1,  1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'hFF, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'h00, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{STEP_CSR,  8'd0,  1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'h5A, 1'b1, 1'b0, 8'h00},
      '{STEP_BYTE, 8'h00, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'hA5, 1'b1, 1'b0, 8'h00},
      '{STEP_CSR,  8'd63, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'hFF, 1'b1, 1'b0, 8'h00},
      '{STEP_CSR,  8'd33, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'h01, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'h80, 1'b1, 1'b0, 8'h00},
      '{STEP_CSR,  8'd31, 1'b0, 1'b0, 8'h00},
      '{STEP_BYTE, 8'h7F, 1'b1, 1'b0, 8'h00},
      '{STEP_CSR,  8'd32, 1'b0, 1'b0, 8'h00}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [shb_pkg::DIGEST_LEN_W-1:0] csr_wr_data;

   shb_req_if req_if ();
   shb_rsp_if rsp_if ();

   sha256_byte_stream_hasher_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state.
   logic [31:0] sha_hash [8];
   logic [31:0] sha_block [16];
   int unsigned sha_fill;
   logic [63:0] sha_bit_count;
   logic        sha_len_overflow;
   logic [shb_pkg::DIGEST_LEN_W-1:0] digest_len_cfg;

   digest_beat_t digest_expect_q [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned bytes_sent = 0;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_restart();
      for (int i = 0; i < 8; i++) sha_hash[i] = SHA_H0[i];
      sha_fill = 0;
      sha_bit_count = '0;
      sha_len_overflow = 1'b0;
   endfunction

   function automatic void sha_compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = sha_block[t];
      for (int t = 16; t < 64; t++) begin
         s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = sha_hash[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) sha_hash[i] = sha_hash[i] + v[i];
      sha_fill = 0;
   endfunction

   function automatic void sha_absorb(input logic [7:0] b);
      int unsigned pos;
      pos = sha_fill % 64;
      sha_block[pos / 4][8 * (3 - pos % 4) +: 8] = b;
      sha_fill = pos + 1;
      if (sha_fill >= 64) sha_compress();
   endfunction

   // Absorbs one message byte; on the last one pads, finishes the hash and queues the
   // digest beats that the block should emit.
   function automatic void predict_digest(input logic [7:0] b, input logic last);
      logic [63:0]  prev_count;
      int unsigned  beats;
      logic [31:0]  word;
      digest_beat_t beat;
      prev_count = sha_bit_count;
      sha_bit_count = prev_count + 64'd8;
      if (sha_bit_count < prev_count) sha_len_overflow = 1'b1;
      sha_absorb(b);
      if (!last) return;
      // Too little room for the length field: the marker and zeros fill this block and the zeros run on into a new one.
      if (sha_fill >= shb_pkg::LENGTH_AT) begin
         sha_absorb(shb_pkg::PAD_MARK);
         while (sha_fill != 0) sha_absorb(8'h00);
      end else begin
         sha_absorb(shb_pkg::PAD_MARK);
      end
      while (sha_fill < shb_pkg::LENGTH_AT) sha_absorb(8'h00);
      for (int i = 7; i >= 0; i--) sha_absorb(sha_bit_count[8 * i +: 8]);
      beats = (digest_len_cfg > 32) ? 32 : digest_len_cfg;
      for (int k = 0; k < beats; k++) begin
         word = sha_hash[k / 4];
         beat.digest_byte = word[8 * (3 - k % 4) +: 8];
         beat.last_of_digest = (k + 1 == beats);
         beat.length_error = sha_len_overflow;
         digest_expect_q.push_back(beat);
      end
      sha_restart();
   endfunction

   // Called at a falling edge; returns at the falling edge after the byte is accepted.
   task automatic send_msg_byte(input logic [7:0] b, input logic last,
                                input logic has_typed, input logic [7:0] typed_byte);
      int unsigned start_size;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.message_byte = b;
      req_if.last_byte = last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      start_size = digest_expect_q.size();
      predict_digest(b, last);
      if (has_typed && digest_expect_q.size() > start_size)
         digest_expect_q[start_size].digest_byte = typed_byte;
      bytes_sent++;
      @(negedge clock);
   endtask

   // The block must be idle for a register write: all digests out, then a pause long
   // enough for a message that emits nothing to finish its padding blocks.
   task automatic write_digest_len(input logic [shb_pkg::DIGEST_LEN_W-1:0] len);
      req_if.valid = 1'b0;
      while (digest_expect_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = len;
      digest_len_cfg = len;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // Digest beat checker.
   always @(posedge clock) begin
      digest_beat_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (digest_expect_q.size() == 0) begin
            $error("digest beat with nothing expected: byte %h", rsp_if.digest_byte);
            mismatches++;
         end else begin
            want = digest_expect_q.pop_front();
            if (rsp_if.digest_byte !== want.digest_byte) begin
               $error("digest_byte: expected %h, got %h", want.digest_byte, rsp_if.digest_byte);
               mismatches++;
            end
            if (rsp_if.last_of_digest !== want.last_of_digest) begin
               $error("last_of_digest: expected %b, got %b",
                      want.last_of_digest, rsp_if.last_of_digest);
               mismatches++;
            end
            if (rsp_if.length_error !== want.length_error) begin
               $error("length_error: expected %b, got %b",
                      want.length_error, rsp_if.length_error);
               mismatches++;
            end
         end
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int unsigned phase_goal;
      int unsigned msg_len;
      logic [shb_pkg::DIGEST_LEN_W-1:0] new_len;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.message_byte = '0;
      req_if.last_byte = 1'b0;
      digest_len_cfg = shb_pkg::DIGEST_LEN_RESET;
      for (int i = 0; i < 16; i++) sha_block[i] = '0;
      sha_restart();
      repeat (4) @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < N_ROWS; r++) begin
         if (DIRECTED_ROWS[r].kind == STEP_CSR)
            write_digest_len(DIRECTED_ROWS[r].value[shb_pkg::DIGEST_LEN_W-1:0]);
         else
            send_msg_byte(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].last,
                          DIRECTED_ROWS[r].has_typed, DIRECTED_ROWS[r].typed_byte);
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         phase_goal = bytes_sent + RANDOM_PER_PHASE;
         while (bytes_sent < phase_goal) begin
            if ($urandom_range(3) == 0) begin
               case ($urandom_range(7))
                  0: new_len = 6'd0;
                  1: new_len = 6'd1;
                  2: new_len = 6'd31;
                  3: new_len = 6'd32;
                  4: new_len = 6'd33;
                  5: new_len = 6'd63;
                  default: new_len = 6'($urandom_range(63));
               endcase
               write_digest_len(new_len);
            end
            // Mostly short messages; some cross the padding and block boundaries.
            case ($urandom_range(19))
               0, 1: begin
                  case ($urandom_range(7))
                     0: msg_len = 55;
                     1: msg_len = 56;
                     2: msg_len = 57;
                     3: msg_len = 63;
                     4: msg_len = 64;
                     5: msg_len = 65;
                     6: msg_len = 119;
                     default: msg_len = 120;
                  endcase
               end
               2, 3, 4: msg_len = $urandom_range(64, 9);
               default: msg_len = $urandom_range(8, 1);
            endcase
            for (int i = 0; i < msg_len; i++)
               send_msg_byte(8'($urandom_range(255)), (i == msg_len - 1), 1'b0, 8'h00);
         end
      end

      req_if.valid = 1'b0;
      while (digest_expect_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && digest_expect_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

/* sha256_byte_stream_hasher_core.f */
+incdir+hdl
hdl/shb_pkg.sv
hdl/shb_channel_if.sv
hdl/sha256_byte_stream_hasher_core.sv
test/testbench.sv
